// ----- design/mkdb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mkdb_pkg
// Shared types, constants and helpers for the multi-key debounce block.
// ----------------------------------------------------------------------------
package mkdb_pkg;

    localparam int NUM_KEYS_DEF = 8;
    localparam int CNT_W        = 10;
    localparam int LEVEL_W      = 8;
    localparam int KEYS_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int KEY_IDX_W    = 3;

    localparam logic [CNT_W-1:0]  DEBOUNCE_RESET = CNT_W'(20);
    localparam logic [CNT_W-1:0]  POLL_RESET     = CNT_W'(100);
    localparam logic [KEYS_W-1:0] KEYS_RESET     = KEYS_W'(8);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_POLL     = 2'd1,
        REG_ACTIVE   = 2'd2,
        REG_KEYS     = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_HELD     = 2'd2
    } key_phase_t;

    typedef struct packed {
        logic hit;
        logic press;
    } lane_evt_t;

    function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
        at_least_one = (v == '0) ? CNT_W'(1) : v;
    endfunction

endpackage
`default_nettype wire

// ----- design/multi_key_debounce_press_release.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// multi_key_debounce_press_release
// Per-key debounce with press and release reporting, one lane per key.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_axis   in         tdata[7:0] key levels, one tick per transfer
//  m_axis   out        tdata[2:0] key index, tuser pressed, tlast last event
//  cfg      in         cfg_index register, cfg_data value
//
// A tick that causes no event leaves the input ready; a tick with events keeps
// the input stalled while the merge stage sends one event per cycle whenever
// the output register is free. The output register lets the next tick enter
// while the final event still waits. Reset loads the default registers, puts
// every key in idle and sets the previous levels to all ones.
// ----------------------------------------------------------------------------
module multi_key_debounce_press_release
#(
    parameter int NUM_KEYS = mkdb_pkg::NUM_KEYS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,   // [7:0] key_levels
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [2:0] key_index
    output logic                                m_axis_tuser,   // [0] pressed
    output logic                                m_axis_tlast,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mkdb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mkdb_pkg::CNT_W-1:0]     cfg_data
);
    import mkdb_pkg::*;

    logic [CNT_W-1:0]    debounce_reg;
    logic [CNT_W-1:0]    poll_reg;
    logic [LEVEL_W-1:0]  active_reg;
    logic [KEYS_W-1:0]   keys_reg;
    logic [NUM_KEYS-1:0] prev_reg;
    logic [NUM_KEYS-1:0] levels;
    logic [NUM_KEYS-1:0] acts;
    logic [CNT_W-1:0]    debounce_load;
    logic [CNT_W-1:0]    poll_load;
    logic                accept;
    logic                merge_idle;
    lane_evt_t [NUM_KEYS-1:0] evt;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = merge_idle;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign debounce_load = at_least_one(debounce_reg);
    assign poll_load     = at_least_one(poll_reg);

    always_comb
    begin
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            levels[i] = (i < LEVEL_W) ? s_axis_tdata[i % LEVEL_W] : 1'b0;
            acts[i]   = (i < LEVEL_W) ? active_reg[i % LEVEL_W] : 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            poll_reg     <= POLL_RESET;
            active_reg   <= '0;
            keys_reg     <= KEYS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEBOUNCE: debounce_reg <= cfg_data;
                REG_POLL:     poll_reg     <= cfg_data;
                REG_ACTIVE:   active_reg   <= cfg_data[LEVEL_W-1:0];
                REG_KEYS:     keys_reg     <= cfg_data[KEYS_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '1;
        end
        else if (accept)
        begin
            prev_reg <= levels;
        end
    end

    for (genvar g = 0; g < NUM_KEYS; g++)
    begin : g_lane
        mkdb_lane u_lane
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .step          (accept),
            .en            ({1'b0, keys_reg} > 5'(g)),
            .level         (levels[g]),
            .prev          (prev_reg[g]),
            .act           (acts[g]),
            .debounce_load (debounce_load),
            .poll_load     (poll_load),
            .evt           (evt[g])
        );
    end

    mkdb_merge
    #(
        .NUM_KEYS (NUM_KEYS)
    )
    u_merge
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .evt           (evt),
        .idle          (merge_idle),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ----- design/mkdb_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mkdb_lane
// Debounce and hold tracking for a single key, advanced once per tick while enabled.
// ----------------------------------------------------------------------------
module mkdb_lane
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       step,
    input  wire logic                       en,
    input  wire logic                       level,
    input  wire logic                       prev,
    input  wire logic                       act,
    input  wire logic [mkdb_pkg::CNT_W-1:0] debounce_load,
    input  wire logic [mkdb_pkg::CNT_W-1:0] poll_load,
    output mkdb_pkg::lane_evt_t             evt
);
    import mkdb_pkg::*;

    key_phase_t       phase_reg;
    key_phase_t       phase_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [CNT_W-1:0] cnt_dec;
    logic             is_active;
    logic             expired;

    assign cnt_dec   = cnt_reg - CNT_W'(1);
    assign expired   = (cnt_dec == '0);
    assign is_active = (level == act);

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        unique case (phase_reg)
            PH_DEBOUNCE:
            begin
                cnt_next = cnt_dec;
                if (expired)
                begin
                    if (is_active)
                    begin
                        phase_next = PH_HELD;
                        cnt_next   = poll_load;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_HELD:
            begin
                cnt_next = cnt_dec;
                if (expired)
                begin
                    if (is_active)
                    begin
                        cnt_next = poll_load;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                if (prev && !level)
                begin
                    phase_next = PH_DEBOUNCE;
                    cnt_next   = debounce_load;
                end
            end
        endcase
    end

    always_comb
    begin
        evt.hit   = 1'b0;
        evt.press = 1'b0;
        unique case (phase_reg)
            PH_DEBOUNCE:
            begin
                evt.hit   = en && expired && is_active;
                evt.press = 1'b1;
            end
            PH_HELD:
            begin
                evt.hit   = en && expired && !is_active;
                evt.press = 1'b0;
            end
            default:
            begin
                evt.hit   = 1'b0;
                evt.press = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
        end
        else if (step && en)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/mkdb_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mkdb_merge
// Collects one tick's lane events and sends them out in ascending key order.
// ----------------------------------------------------------------------------
module mkdb_merge
#(
    parameter int NUM_KEYS = mkdb_pkg::NUM_KEYS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               load,
    input  wire mkdb_pkg::lane_evt_t [NUM_KEYS-1:0] evt,
    output logic                                    idle,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [7:0]                              m_axis_tdata,
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast
);
    import mkdb_pkg::*;

    localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

    logic [NUM_KEYS-1:0]  pend_reg;
    logic [NUM_KEYS-1:0]  pend_next;
    logic [NUM_KEYS-1:0]  press_reg;
    logic [NUM_KEYS-1:0]  low_bit;
    logic [NUM_KEYS-1:0]  rest;
    logic [IDX_W-1:0]     sel_idx;
    logic                 out_free;
    logic                 move;

    logic                 out_valid_reg;
    logic [KEY_IDX_W-1:0] out_idx_reg;
    logic                 out_press_reg;
    logic                 out_last_reg;

    assign low_bit  = pend_reg & (~pend_reg + NUM_KEYS'(1));
    assign rest     = pend_reg & ~low_bit;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign move     = out_free && (pend_reg != '0);
    assign idle     = (pend_reg == '0);

    always_comb
    begin
        sel_idx = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                sel_idx = IDX_W'(i);
            end
        end
    end

    always_comb
    begin
        pend_next = pend_reg;
        if (load)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                pend_next[i] = evt[i].hit;
            end
        end
        else if (move)
        begin
            pend_next = rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_KEYS; i++)
            begin
                press_reg[i] <= evt[i].press;
            end
        end
        if (move)
        begin
            out_idx_reg   <= KEY_IDX_W'(sel_idx);
            out_press_reg <= |(low_bit & press_reg);
            out_last_reg  <= (rest == '0);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(8 - KEY_IDX_W){1'b0}}, out_idx_reg};
    assign m_axis_tuser  = out_press_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ----- verif/mkdb_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mkdb_checker
// Passive checker for the multi-key debounce block. It follows every register
// write and every accepted tick, keeps its own copy of each key's phase and
// countdown, works out the press and release events that the tick causes, and
// compares each event transfer on the output channel with the oldest one due.
// ----------------------------------------------------------------------------
module mkdb_checker
#(
    parameter int NUM_KEYS = mkdb_pkg::NUM_KEYS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    input  wire logic                           s_axis_tready,
    input  wire logic [7:0]                     s_axis_tdata,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [7:0]                     m_axis_tdata,
    input  wire logic                           m_axis_tuser,
    input  wire logic                           m_axis_tlast,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [mkdb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [mkdb_pkg::CNT_W-1:0]     cfg_data,
    output int                                  errors,
    output int                                  pending
);
    import mkdb_pkg::*;

    typedef struct packed {
        logic [KEY_IDX_W-1:0] key;
        logic                 pressed;
        logic                 last;
    } key_event_t;

    key_event_t          events_due[$];
    logic [CNT_W-1:0]    debounce_len;
    logic [CNT_W-1:0]    poll_len;
    logic [LEVEL_W-1:0]  active_mask;
    logic [KEYS_W-1:0]   enabled_keys;
    key_phase_t          phase [NUM_KEYS];
    logic [CNT_W-1:0]    remaining [NUM_KEYS];
    logic [NUM_KEYS-1:0] last_levels;

    function automatic logic [CNT_W-1:0] reload(input logic [CNT_W-1:0] period);
        return (period == '0) ? CNT_W'(1) : period;
    endfunction

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CNT_W-1:0] value);
        case (cfg_reg_t'(idx))
            REG_DEBOUNCE: debounce_len = value;
            REG_POLL:     poll_len = value;
            REG_ACTIVE:   active_mask = value[LEVEL_W-1:0];
            REG_KEYS:     enabled_keys = value[KEYS_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic predict_tick(input logic [LEVEL_W-1:0] levels);
        key_event_t tick_events[$];
        key_event_t ev;
        int         lim;
        logic       lvl;
        logic       at_pressed_level;
        lim = (enabled_keys > NUM_KEYS) ? NUM_KEYS : int'(enabled_keys);
        for (int k = 0; k < lim; k++)
        begin
            lvl = levels[k];
            at_pressed_level = (lvl == active_mask[k]);
            ev.key = KEY_IDX_W'(k);
            ev.last = 1'b0;
            case (phase[k])
                PH_DEBOUNCE:
                begin
                    remaining[k] = remaining[k] - 1'b1;
                    if (remaining[k] == '0)
                    begin
                        if (at_pressed_level)
                        begin
                            phase[k] = PH_HELD;
                            remaining[k] = reload(poll_len);
                            ev.pressed = 1'b1;
                            tick_events.push_back(ev);
                        end
                        else
                            phase[k] = PH_IDLE;
                    end
                end
                PH_HELD:
                begin
                    remaining[k] = remaining[k] - 1'b1;
                    if (remaining[k] == '0)
                    begin
                        if (at_pressed_level)
                            remaining[k] = reload(poll_len);
                        else
                        begin
                            phase[k] = PH_IDLE;
                            ev.pressed = 1'b0;
                            tick_events.push_back(ev);
                        end
                    end
                end
                default:
                begin
                    phase[k] = PH_IDLE;
                    if (last_levels[k] && !lvl)
                    begin
                        phase[k] = PH_DEBOUNCE;
                        remaining[k] = reload(debounce_len);
                    end
                end
            endcase
        end
        if (tick_events.size() > 0)
        begin
            ev = tick_events[tick_events.size() - 1];
            ev.last = 1'b1;
            tick_events[tick_events.size() - 1] = ev;
        end
        foreach (tick_events[j])
            events_due.push_back(tick_events[j]);
        last_levels = levels[NUM_KEYS-1:0];
    endtask

    task automatic check_event();
        key_event_t seen;
        key_event_t want;
        seen.key = m_axis_tdata[KEY_IDX_W-1:0];
        seen.pressed = m_axis_tuser;
        seen.last = m_axis_tlast;
        if (events_due.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected key event: key %0d pressed %0b last %0b",
                         seen.key, seen.pressed, seen.last);
        end
        else
        begin
            want = events_due.pop_front();
            if (seen.key != want.key || seen.pressed != want.pressed ||
                seen.last != want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"key event mismatch: expected key %0d pressed %0b last %0b,",
                              " got key %0d pressed %0b last %0b"},
                             want.key, want.pressed, want.last,
                             seen.key, seen.pressed, seen.last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_len = DEBOUNCE_RESET;
            poll_len = POLL_RESET;
            active_mask = '0;
            enabled_keys = KEYS_RESET;
            for (int k = 0; k < NUM_KEYS; k++)
            begin
                phase[k] = PH_IDLE;
                remaining[k] = '0;
            end
            last_levels = '1;
            events_due.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (m_axis_tvalid && m_axis_tready)
                check_event();
            if (s_axis_tvalid && s_axis_tready)
                predict_tick(s_axis_tdata);
            pending = events_due.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives key level ticks and register writes into the multi-key debounce
// block. A short directed part covers all-high and all-low levels, zero
// periods, an oversized key count and disabled keys; random phases then move
// keys through bounces, presses, holds and releases under several register
// settings while both channels idle at random. The checker judges events.
// ----------------------------------------------------------------------------
module testbench;
    import mkdb_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tuser;
    logic                 m_axis_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0]     cfg_data;

    int         check_errors;
    int         events_pending;
    int         cycle_count = 0;
    bit         quiet = 1'b0;
    bit         hold_req = 1'b0;
    bit         hold_done = 1'b0;
    logic [7:0] key_state;

    logic [7:0] first_ticks [17] = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF,
                                     8'h00, 8'h00, 8'h0F, 8'hF0, 8'hAA, 8'h55, 8'hFF,
                                     8'h00, 8'h00, 8'hFF};
    logic [7:0] second_ticks [6] = '{8'hFF, 8'h00, 8'h00, 8'h5A, 8'hFF, 8'hFF};

    multi_key_debounce_press_release u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mkdb_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (check_errors),
        .pending       (events_pending)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("[multi_key_debounce_press_release] ERROR");
            $finish;
        end
    end

    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
                m_axis_tready <= 1'b1;
            end
            else if (!quiet && rst_n && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    task automatic send_tick(input logic [7:0] levels);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= levels;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic run_ticks(input int count, input int flip_odds);
        logic [7:0] flips;
        for (int n = 0; n < count; n++)
        begin
            for (int b = 0; b < 8; b++)
                flips[b] = ($urandom_range(1, flip_odds) == 1);
            key_state = key_state ^ flips;
            if ($urandom_range(0, 9) == 0)
                send_tick(8'($urandom));
            else
                send_tick(key_state);
        end
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (events_pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic configure(input logic [CNT_W-1:0] debounce_val, input logic [CNT_W-1:0] poll_val,
                             input logic [CNT_W-1:0] active_val, input logic [CNT_W-1:0] keys_val);
        cfg_reg_t         order [4] = '{REG_DEBOUNCE, REG_POLL, REG_ACTIVE, REG_KEYS};
        logic [CNT_W-1:0] values [4];
        values = '{debounce_val, poll_val, active_val, keys_val};
        for (int r = 0; r < 4; r++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= order[r];
            cfg_data  <= values[r];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '1;
        cfg_valid = 1'b0;
        cfg_index = REG_DEBOUNCE;
        cfg_data = '0;
        key_state = '1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_ticks(30, 30);
        settle();

        configure(10'd0, 10'd0, 10'd0, 10'd15);
        foreach (first_ticks[i])
            send_tick(first_ticks[i]);
        settle();

        configure(10'd2, 10'd1023, 10'h3A5, 10'd3);
        foreach (second_ticks[i])
            send_tick(second_ticks[i]);
        settle();

        configure(10'd3, 10'd5, 10'($urandom_range(0, 1023)), 10'd8);
        run_ticks(80, 5);
        settle();

        configure(10'd1, 10'd1, 10'h0FF, 10'd0);
        run_ticks(15, 3);
        settle();

        configure(10'd1023, 10'd1023, 10'd0, 10'd5);
        run_ticks(15, 4);
        settle();

        configure(10'd2, 10'd4, 10'h03C, 10'd8);
        run_ticks(20, 5);
        hold_req = 1'b1;
        run_ticks(40, 5);
        settle();

        configure(10'd1, 10'd2, 10'($urandom_range(0, 1023)), 10'd6);
        run_ticks(40, 4);
        settle();

        quiet = 1'b1;
        configure(10'd4, 10'd3, 10'h00F, 10'd8);
        run_ticks(60, 5);
        settle();

        if (check_errors == 0 && events_pending == 0)
            $display("[multi_key_debounce_press_release] OK");
        else
            $display("[multi_key_debounce_press_release] ERROR");
        $finish;
    end

endmodule
